FILE: hdl/radio_frame_sensor_deframer_top_assert.svh
// ============================================================================
// radio frame sensor deframer assertion macros
// concurrent assertion helpers, empty when synthesis is defined
// ============================================================================
`ifndef RADIO_FRAME_SENSOR_DEFRAMER_TOP_ASSERT_SVH
`define RADIO_FRAME_SENSOR_DEFRAMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RFSD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deframer assertion failed");
// next-cycle implication
`define RFSD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deframer assertion failed");
`else
`define RFSD_ASSERT_IMP(lbl, ante, cons)
`define RFSD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/rfsd_pkg.sv
// ============================================================================
// rfsd_pkg
// constants of the sensor frame format shared by the deframer
// ============================================================================
`timescale 1ns / 1ps

package rfsd_pkg;

    localparam logic [7:0] FRAME_DELIM = 8'h7E;
    localparam logic [7:0] LEN_HIGH    = 8'h00;
    localparam logic [7:0] LEN_LOW     = 8'h14;
    localparam logic [7:0] GOOD_SUM    = 8'hFF;

    localparam int BODY_BYTES  = 21;
    localparam int STAGE_FIRST = 10;
    localparam int STAGE_COUNT = 10;
    localparam int VALUE_COUNT = 5;
    localparam int VALUE_W     = 16;

    localparam int IDX_W = 5;
    localparam int SIDX_W = 4;

    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(BODY_BYTES - 1);
    localparam logic [IDX_W-1:0] IDX_SFIRST = IDX_W'(STAGE_FIRST);
    localparam logic [IDX_W-1:0] IDX_SEND  = IDX_W'(STAGE_FIRST + STAGE_COUNT);

    localparam int OUT_W = VALUE_COUNT * VALUE_W;

endpackage

FILE: hdl/radio_frame_sensor_deframer_top.sv
// ============================================================================
// radio_frame_sensor_deframer_top
// parses fixed-size sensor api frames from a byte stream and emits held values
// ============================================================================
// an accepted byte ending a frame reaches m_ as a result via the input and output registers
// throughput: one byte per cycle while the result side is not stalled
// an input register and an output register part the two sides
// reset: synchronous active-low aresetn clears parser state, held values, valids
`timescale 1ns / 1ps

module radio_frame_sensor_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // accel_z, accel_y, accel_x, emg_first, emg_second
    output logic [0:0]  m_tuser    // [0] checksum_ok
);

    `include "radio_frame_sensor_deframer_top_assert.svh"

    // parser phases
    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_LENHI = 2'd1,
        PH_LENLO = 2'd2,
        PH_BODY  = 2'd3
    } phase_t;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // parser state
    phase_t                          phase_reg, phase_next;
    logic [rfsd_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [7:0]                      sum_reg, sum_next;
    logic [7:0]                      staged_reg [rfsd_pkg::STAGE_COUNT];
    logic [rfsd_pkg::VALUE_W-1:0]    held_reg  [rfsd_pkg::VALUE_COUNT];
    logic [rfsd_pkg::VALUE_W-1:0]    held_next [rfsd_pkg::VALUE_COUNT];

    // output register
    logic                            out_valid_reg, out_valid_next;
    logic [rfsd_pkg::OUT_W-1:0]      out_data_reg, out_data_next;
    logic                            out_ok_reg, out_ok_next;

    logic                            proc_go;     // byte in input register is consumed
    logic                            frame_end;   // consumed byte is the last body byte
    logic                            sum_good;
    logic                            stage_wr;
    logic [rfsd_pkg::SIDX_W-1:0]     stage_idx;
    logic [7:0]                      sum_add;

    // consume the held byte when the result register is free or being drained
    assign proc_go   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_go;
    assign frame_end = proc_go && (phase_reg == PH_BODY) && (idx_reg == rfsd_pkg::IDX_LAST);

    assign sum_add   = sum_reg + in_byte_reg;
    assign sum_good  = (sum_add == rfsd_pkg::GOOD_SUM);
    assign stage_wr  = proc_go && (phase_reg == PH_BODY)
                       && (idx_reg >= rfsd_pkg::IDX_SFIRST) && (idx_reg < rfsd_pkg::IDX_SEND);
    assign stage_idx = rfsd_pkg::SIDX_W'(idx_reg - rfsd_pkg::IDX_SFIRST);

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (proc_go) begin
            in_valid_next = 1'b0;
        end

        phase_next = phase_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        if (proc_go) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (in_byte_reg == rfsd_pkg::FRAME_DELIM) begin
                        phase_next = PH_LENHI;
                    end
                end
                PH_LENHI: begin
                    // a wrong length byte is dropped, not retested as delimiter
                    phase_next = (in_byte_reg == rfsd_pkg::LEN_HIGH) ? PH_LENLO : PH_HUNT;
                end
                PH_LENLO: begin
                    phase_next = (in_byte_reg == rfsd_pkg::LEN_LOW) ? PH_BODY : PH_HUNT;
                    idx_next   = '0;
                    sum_next   = '0;
                end
                PH_BODY: begin
                    if (idx_reg == rfsd_pkg::IDX_LAST) begin
                        phase_next = PH_HUNT;
                        idx_next   = '0;
                        sum_next   = '0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        sum_next = sum_add;
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        // big-endian pairs from staged bytes, updated only on a good checksum
        for (int k = 0; k < rfsd_pkg::VALUE_COUNT; k++) begin
            held_next[k] = (frame_end && sum_good)
                           ? {staged_reg[2*k], staged_reg[2*k+1]} : held_reg[k];
        end

        out_valid_next = out_valid_reg;
        if (frame_end) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        out_data_next = out_data_reg;
        out_ok_next   = out_ok_reg;
        if (frame_end) begin
            for (int k = 0; k < rfsd_pkg::VALUE_COUNT; k++) begin
                out_data_next[k*rfsd_pkg::VALUE_W +: rfsd_pkg::VALUE_W] = held_next[k];
            end
            out_ok_next = sum_good;
        end
    end

    // control state and held values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_HUNT;
            idx_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < rfsd_pkg::VALUE_COUNT; k++) begin
                held_reg[k] <= '0;
            end
        end else begin
            in_valid_reg  <= in_valid_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            for (int k = 0; k < rfsd_pkg::VALUE_COUNT; k++) begin
                held_reg[k] <= held_next[k];
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (stage_wr) begin
            staged_reg[stage_idx] <= in_byte_reg;
        end
        out_data_reg <= out_data_next;
        out_ok_reg   <= out_ok_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_ok_reg;

    // index and sum only move while collecting a body
    `RFSD_ASSERT_IMP(a_idx_idle, phase_reg != PH_BODY, idx_reg == '0 && sum_reg == '0)
    `RFSD_ASSERT_IMP(a_idx_range, 1'b1, idx_reg <= rfsd_pkg::IDX_LAST)
    // the last body byte always yields a result next cycle
    `RFSD_ASSERT_NXT(a_end_emits, frame_end, out_valid_reg)
    // a new result only ever follows a frame end
    `RFSD_ASSERT_IMP(a_result_cause, out_valid_reg && !$past(out_valid_reg),
                     $past(frame_end))
    // a byte is never consumed while the result register is full and stalled
    `RFSD_ASSERT_IMP(a_no_overrun, out_valid_reg && !m_tready, !proc_go)

endmodule

FILE: bench/tb_radio_frame_sensor_deframer_top.sv
// ============================================================================
// tb_radio_frame_sensor_deframer_top
// byte-stream testbench for the sensor frame deframer: a directed set of frames
// and broken headers, then random frames, noise and bad checksums, with random
// gaps on the input side and random back-pressure on the result side; every
// result transfer is checked field by field against a local frame parser
// ============================================================================
`timescale 1ns / 1ps

module tb_radio_frame_sensor_deframer_top;

    // idle cycles with no transfer on either side before the run is abandoned
    localparam int WATCHDOG_LIMIT = 4000;
    // settling time after the last expected result
    localparam int DRAIN_CYCLES   = 8;
    // rough size of the random part, in bytes
    localparam int RANDOM_BYTES   = 1000;

    // parser phases of the local prediction
    typedef enum logic [1:0] {
        SEEK_DELIM,
        SEEK_LEN_HI,
        SEEK_LEN_LO,
        TAKE_BODY
    } deframe_phase_t;

    // one expected result: held values (z, y, x, emg first, emg second) and flag
    typedef struct {
        logic [rfsd_pkg::VALUE_W-1:0] value [rfsd_pkg::VALUE_COUNT];
        logic                         checksum_ok;
    } sensor_reading_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [0:0]  m_tuser;

    radio_frame_sensor_deframer_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // stimulus and scoreboard storage
    logic [7:0]      pending_bytes [$];
    sensor_reading_t expected_readings [$];
    logic [7:0]      frame_data [rfsd_pkg::BODY_BYTES-1];
    int              bytes_total;
    int              bytes_taken;
    int              fail_count;

    // local copy of the parser state
    deframe_phase_t               phase;
    int                           body_pos;
    logic [7:0]                   body_sum;
    logic [7:0]                   staged [rfsd_pkg::STAGE_COUNT];
    logic [rfsd_pkg::VALUE_W-1:0] held [rfsd_pkg::VALUE_COUNT];

    // pacing state of both sides
    int   byte_gap;
    int   result_stall;
    bit   steady_in;
    bit   steady_out;
    int   idle_cycles;

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_count++;
    endtask

    // queues the header, the 20 data bytes in frame_data and a checksum byte
    task automatic push_frame(input bit good);
        logic [7:0] sum;
        logic [7:0] chk;
        sum = 8'h00;
        pending_bytes.push_back(rfsd_pkg::FRAME_DELIM);
        pending_bytes.push_back(rfsd_pkg::LEN_HIGH);
        pending_bytes.push_back(rfsd_pkg::LEN_LOW);
        for (int i = 0; i < rfsd_pkg::BODY_BYTES - 1; i++) begin
            pending_bytes.push_back(frame_data[i]);
            sum = sum + frame_data[i];
        end
        chk = rfsd_pkg::GOOD_SUM - sum;
        if (!good)
            chk = chk + 8'($urandom_range(1, 255));
        pending_bytes.push_back(chk);
    endtask

    // random payload, leaning on the extremes and on the delimiter value
    task automatic fill_random_payload();
        int r;
        for (int i = 0; i < rfsd_pkg::BODY_BYTES - 1; i++) begin
            r = $urandom_range(0, 15);
            case (r)
                0:       frame_data[i] = 8'h00;
                1:       frame_data[i] = 8'hFF;
                2:       frame_data[i] = rfsd_pkg::FRAME_DELIM;
                default: frame_data[i] = 8'($urandom);
            endcase
        end
    endtask

    // frame parser: advances on one accepted byte, queues a result on frame end
    task automatic deframe_byte(input logic [7:0] b);
        sensor_reading_t reading;
        case (phase)
            SEEK_DELIM: begin
                if (b == rfsd_pkg::FRAME_DELIM)
                    phase = SEEK_LEN_HI;
            end
            SEEK_LEN_HI: begin
                // a bad length byte is swallowed, never re-tested as delimiter
                phase = (b == rfsd_pkg::LEN_HIGH) ? SEEK_LEN_LO : SEEK_DELIM;
            end
            SEEK_LEN_LO: begin
                if (b == rfsd_pkg::LEN_LOW) begin
                    phase    = TAKE_BODY;
                    body_pos = 0;
                    body_sum = 8'h00;
                end else begin
                    phase = SEEK_DELIM;
                end
            end
            TAKE_BODY: begin
                // delimiter value is plain data here
                body_sum = body_sum + b;
                if (body_pos >= rfsd_pkg::STAGE_FIRST
                    && body_pos < rfsd_pkg::STAGE_FIRST + rfsd_pkg::STAGE_COUNT)
                    staged[body_pos - rfsd_pkg::STAGE_FIRST] = b;
                if (body_pos < rfsd_pkg::BODY_BYTES - 1) begin
                    body_pos++;
                end else begin
                    reading.checksum_ok = (body_sum == rfsd_pkg::GOOD_SUM);
                    // bad checksum keeps the previously held values
                    if (reading.checksum_ok) begin
                        for (int k = 0; k < rfsd_pkg::VALUE_COUNT; k++)
                            held[k] = {staged[2*k], staged[2*k+1]};
                    end
                    reading.value = held;
                    expected_readings.push_back(reading);
                    phase    = SEEK_DELIM;
                    body_pos = 0;
                    body_sum = 8'h00;
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // byte driver: one item per transfer, random gaps between items
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            byte_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (byte_gap != 0) begin
                s_tvalid <= 1'b0;
                byte_gap <= byte_gap - 1;
            end else if (pending_bytes.size() != 0) begin
                s_tdata  <= pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                byte_gap <= steady_in ? 0 : pick_gap();
                // now and then switch to or from a stretch without gaps
                if ($urandom_range(0, 99) == 0)
                    steady_in <= !steady_in;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result side back-pressure
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready     <= 1'b0;
            result_stall <= 0;
        end else if (result_stall != 0) begin
            m_tready     <= 1'b0;
            result_stall <= result_stall - 1;
        end else begin
            m_tready     <= 1'b1;
            result_stall <= steady_out ? 0 : pick_gap();
            if ($urandom_range(0, 199) == 0)
                steady_out <= !steady_out;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on each byte transfer, checks each result transfer
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        sensor_reading_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata);
                bytes_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected, tdata %h",
                                              m_tdata));
                end else begin
                    want = expected_readings.pop_front();
                    // tdata from the lowest bit: z, y, x, emg first, emg second
                    for (int k = 0; k < rfsd_pkg::VALUE_COUNT; k++) begin
                        if (m_tdata[k*rfsd_pkg::VALUE_W +: rfsd_pkg::VALUE_W]
                            !== want.value[k])
                            report_mismatch($sformatf("value %0d got %h want %h", k,
                                m_tdata[k*rfsd_pkg::VALUE_W +: rfsd_pkg::VALUE_W],
                                want.value[k]));
                    end
                    if (m_tuser[0] !== want.checksum_ok)
                        report_mismatch($sformatf("checksum_ok got %b want %b",
                                                  m_tuser[0], want.checksum_ok));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: abandons the run after a long spell with no transfer at all
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int r;
        bytes_taken = 0;
        fail_count  = 0;
        idle_cycles = 0;
        steady_in   = 1'b0;
        steady_out  = 1'b0;
        phase       = SEEK_DELIM;
        body_pos    = 0;
        body_sum    = 8'h00;
        for (int i = 0; i < rfsd_pkg::STAGE_COUNT; i++)
            staged[i] = 8'h00;
        for (int k = 0; k < rfsd_pkg::VALUE_COUNT; k++)
            held[k] = '0;

        // good frame: delimiter value as data, extreme held values
        for (int i = 0; i < rfsd_pkg::STAGE_FIRST; i++)
            frame_data[i] = rfsd_pkg::FRAME_DELIM;
        {frame_data[10], frame_data[11]} = 16'hFFFF;
        {frame_data[12], frame_data[13]} = 16'h0000;
        {frame_data[14], frame_data[15]} = 16'h8001;
        {frame_data[16], frame_data[17]} = 16'h7E7E;
        {frame_data[18], frame_data[19]} = 16'h00FF;
        push_frame(1'b1);

        // bad first length byte that is itself the delimiter value
        pending_bytes.push_back(rfsd_pkg::FRAME_DELIM);
        pending_bytes.push_back(rfsd_pkg::FRAME_DELIM);
        pending_bytes.push_back(rfsd_pkg::LEN_HIGH);
        pending_bytes.push_back(rfsd_pkg::LEN_LOW);
        // bad second length byte, again the delimiter value
        pending_bytes.push_back(rfsd_pkg::FRAME_DELIM);
        pending_bytes.push_back(rfsd_pkg::LEN_HIGH);
        pending_bytes.push_back(rfsd_pkg::FRAME_DELIM);
        pending_bytes.push_back(rfsd_pkg::LEN_HIGH);
        pending_bytes.push_back(rfsd_pkg::LEN_LOW);

        // bad checksum: held values must survive
        for (int i = 0; i < rfsd_pkg::BODY_BYTES - 1; i++)
            frame_data[i] = 8'h00;
        push_frame(1'b0);
        // all-ones payload, then all-zero payload, both good
        for (int i = 0; i < rfsd_pkg::BODY_BYTES - 1; i++)
            frame_data[i] = 8'hFF;
        push_frame(1'b1);
        for (int i = 0; i < rfsd_pkg::BODY_BYTES - 1; i++)
            frame_data[i] = 8'h00;
        push_frame(1'b1);

        // random part: mostly well-formed frames, some noise and broken headers
        bytes_total = pending_bytes.size() + RANDOM_BYTES;
        while (pending_bytes.size() < bytes_total) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                fill_random_payload();
                push_frame(1'b1);
            end else if (r == 7) begin
                fill_random_payload();
                push_frame(1'b0);
            end else if (r == 8) begin
                repeat ($urandom_range(1, 6))
                    pending_bytes.push_back(8'($urandom));
            end else begin
                pending_bytes.push_back(rfsd_pkg::FRAME_DELIM);
                if ($urandom_range(0, 1) == 0) begin
                    pending_bytes.push_back(rfsd_pkg::LEN_HIGH);
                    pending_bytes.push_back(8'($urandom_range(0, 1) ? rfsd_pkg::FRAME_DELIM
                                                                    : 8'($urandom)));
                end else begin
                    pending_bytes.push_back(8'($urandom_range(1, 255)));
                end
            end
        end
        bytes_total = pending_bytes.size();

        // single reset pulse at the start
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // sampled away from the active edge so monitor updates have settled
        while (bytes_taken < bytes_total || expected_readings.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_readings.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      expected_readings.size()));

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/rfsd_pkg.sv
hdl/radio_frame_sensor_deframer_top.sv
bench/tb_radio_frame_sensor_deframer_top.sv
